### rtl/core/crc8rf_pkg.sv
// ----------------------------------------------------------------------------
// crc8rf_pkg
// Shared types, frame constants and the CRC-8 (poly 0x31, MSB first) update.
// ----------------------------------------------------------------------------
`default_nettype none

package crc8rf_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [2:0] pos_t;

  localparam byte_t SYNC_A      = 8'hAC;
  localparam byte_t SYNC_B      = 8'h53;
  localparam byte_t CRC_POLY    = 8'h31;
  localparam byte_t MAX_PAYLOAD = 8'd250;
  localparam byte_t LEN_BASE    = 8'd4;

  // Result counts and byte positions within one item's burst
  localparam pos_t HDR_CNT_OPEN   = 3'd6;
  localparam pos_t HDR_CNT_CLOSED = 3'd7;
  localparam pos_t PAY_CNT_OPEN   = 3'd1;
  localparam pos_t PAY_CNT_CLOSED = 3'd2;

  localparam pos_t HDR_POS_SYNC_A = 3'd0;
  localparam pos_t HDR_POS_SYNC_B = 3'd1;
  localparam pos_t HDR_POS_LEN    = 3'd2;
  localparam pos_t HDR_POS_SEQ    = 3'd3;
  localparam pos_t HDR_POS_ADDR   = 3'd4;
  localparam pos_t HDR_POS_ACK    = 3'd5;
  localparam pos_t HDR_POS_CRC    = 3'd6;
  localparam pos_t PAY_POS_DATA   = 3'd0;
  localparam pos_t PAY_POS_CRC    = 3'd1;

  // One byte through the CRC-8: eight shift/xor steps
  function automatic byte_t crc8_update(input byte_t crc, input byte_t data);
    byte_t c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/core/crc8rf_in_if.sv
// ----------------------------------------------------------------------------
// crc8rf_in_if
// Input channel: header or payload items, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface crc8rf_in_if import crc8rf_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  is_header;
  byte_t seq_number;
  byte_t address;
  byte_t ack_code;
  byte_t payload_length;
  byte_t payload_byte;

  modport source (
    output valid, is_header, seq_number, address, ack_code, payload_length, payload_byte,
    input  ready
  );
  modport sink (
    input  valid, is_header, seq_number, address, ack_code, payload_length, payload_byte,
    output ready
  );
endinterface

`default_nettype wire

### rtl/core/crc8rf_out_if.sv
// ----------------------------------------------------------------------------
// crc8rf_out_if
// Result channel: one frame byte per transfer, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface crc8rf_out_if import crc8rf_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  frame_end;

  modport source (
    output valid, out_byte, frame_end,
    input  ready
  );
  modport sink (
    input  valid, out_byte, frame_end,
    output ready
  );
endinterface

`default_nettype wire

### rtl/core/crc8_response_framer_unit.sv
// ----------------------------------------------------------------------------
// crc8_response_framer_unit
// Flow: an accepted item is latched into the burst buffer; its bytes then
//   pass through the output register at one per cycle while out_if.ready holds.
// Throughput: open payload items one per cycle while the output does not stall;
//   the closing one holds the input for its data and CRC bytes, a header item
//   for the 6 or 7 frame bytes it produces (set by the single-byte output register).
// Reset (rst_n low, synchronous): no frame open, burst buffer and output empty.
// ----------------------------------------------------------------------------
`default_nettype none

module crc8_response_framer_unit import crc8rf_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  crc8rf_in_if.sink      in_if,
  crc8rf_out_if.source   out_if
);

  // CRC sequencer for header bytes, one byte per cycle after the transfer
  typedef enum logic [1:0] {
    STEP_IDLE,
    STEP_SEQ,
    STEP_ADDR,
    STEP_ACK
  } step_t;

  // Frame state
  logic  frame_open_r, frame_open_nxt;
  byte_t remain_r,     remain_nxt;
  byte_t crc_r,        crc_nxt;
  step_t step_r,       step_nxt;

  // Burst buffer: the accepted item and the bytes it still owes
  logic  hdr_r,   hdr_nxt;
  logic  empty_r, empty_nxt;   // header with no payload: CRC skips ack
  byte_t len_r,   len_nxt;
  byte_t seq_r,   seq_nxt;
  byte_t addr_r,  addr_nxt;
  byte_t ack_r,   ack_nxt;
  byte_t data_r,  data_nxt;
  pos_t  cnt_r,   cnt_nxt;
  pos_t  idx_r,   idx_nxt;

  // Output register
  logic  out_valid_r, out_valid_nxt;
  byte_t out_byte_r,  out_byte_nxt;
  logic  out_end_r,   out_end_nxt;

  logic  in_fire;
  logic  out_load;
  pos_t  pending;
  byte_t size_clamped;
  byte_t len_calc;
  byte_t sel_byte;
  logic  sel_end;

  assign pending  = cnt_r - idx_r;
  assign out_load = (pending != '0) && (!out_valid_r || out_if.ready);

  // Take a new item once the buffer is empty or hands over its last byte now
  assign in_if.ready = (pending == '0) || ((pending == pos_t'(1)) && out_load);
  assign in_fire     = in_if.valid && in_if.ready;

  assign size_clamped = (in_if.payload_length > MAX_PAYLOAD) ? MAX_PAYLOAD
                                                             : in_if.payload_length;
  assign len_calc     = LEN_BASE + size_clamped;

  // Byte at the read position; the CRC comes straight from the running value
  always_comb begin
    sel_byte = crc_r;
    sel_end  = 1'b0;
    if (hdr_r) begin
      unique case (idx_r)
        HDR_POS_SYNC_A: sel_byte = SYNC_A;
        HDR_POS_SYNC_B: sel_byte = SYNC_B;
        HDR_POS_LEN:    sel_byte = len_r;
        HDR_POS_SEQ:    sel_byte = seq_r;
        HDR_POS_ADDR:   sel_byte = addr_r;
        HDR_POS_ACK:    sel_byte = ack_r;
        HDR_POS_CRC: begin
          sel_byte = crc_r;
          sel_end  = 1'b1;
        end
        default:        sel_byte = crc_r;
      endcase
    end else begin
      unique case (idx_r)
        PAY_POS_DATA:   sel_byte = data_r;
        PAY_POS_CRC: begin
          sel_byte = crc_r;
          sel_end  = 1'b1;
        end
        default:        sel_byte = crc_r;
      endcase
    end
  end

  always_comb begin
    frame_open_nxt = frame_open_r;
    remain_nxt     = remain_r;
    crc_nxt        = crc_r;
    step_nxt       = step_r;
    hdr_nxt        = hdr_r;
    empty_nxt      = empty_r;
    len_nxt        = len_r;
    seq_nxt        = seq_r;
    addr_nxt       = addr_r;
    ack_nxt        = ack_r;
    data_nxt       = data_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = out_valid_r;
    out_byte_nxt   = out_byte_r;
    out_end_nxt    = out_end_r;

    // Header CRC: len on transfer, then seq, addr and (if payload) ack.
    // All done before the burst can drain far enough for the CRC byte.
    unique case (step_r)
      STEP_IDLE: ;
      STEP_SEQ: begin
        crc_nxt  = crc8_update(crc_r, seq_r);
        step_nxt = STEP_ADDR;
      end
      STEP_ADDR: begin
        crc_nxt  = crc8_update(crc_r, addr_r);
        step_nxt = empty_r ? STEP_IDLE : STEP_ACK;
      end
      STEP_ACK: begin
        crc_nxt  = crc8_update(crc_r, ack_r);
        step_nxt = STEP_IDLE;
      end
      default:   step_nxt = STEP_IDLE;
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = sel_byte;
      out_end_nxt   = sel_end;
      idx_nxt       = idx_r + pos_t'(1);
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_fire) begin
      idx_nxt = '0;
      hdr_nxt = in_if.is_header;
      if (in_if.is_header) begin
        len_nxt   = len_calc;
        seq_nxt   = in_if.seq_number;
        addr_nxt  = in_if.address;
        ack_nxt   = in_if.ack_code;
        empty_nxt = (size_clamped == '0);
        crc_nxt   = crc8_update('0, len_calc);
        step_nxt  = STEP_SEQ;
        if (size_clamped == '0) begin
          cnt_nxt        = HDR_CNT_CLOSED;
          frame_open_nxt = 1'b0;
          remain_nxt     = '0;
        end else begin
          cnt_nxt        = HDR_CNT_OPEN;
          frame_open_nxt = 1'b1;
          remain_nxt     = size_clamped;
        end
      end else if (frame_open_r && (remain_r != '0)) begin
        data_nxt = in_if.payload_byte;
        if (remain_r == 8'd1) begin
          // last payload byte stays out of the CRC; crc_r is the check byte
          cnt_nxt        = PAY_CNT_CLOSED;
          frame_open_nxt = 1'b0;
          remain_nxt     = '0;
        end else begin
          cnt_nxt    = PAY_CNT_OPEN;
          crc_nxt    = crc8_update(crc_r, in_if.payload_byte);
          remain_nxt = remain_r - 8'd1;
        end
      end else begin
        // stray payload: dropped, nothing to send
        cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
      remain_r     <= '0;
      crc_r        <= '0;
      step_r       <= STEP_IDLE;
      cnt_r        <= '0;
      idx_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      frame_open_r <= frame_open_nxt;
      remain_r     <= remain_nxt;
      crc_r        <= crc_nxt;
      step_r       <= step_nxt;
      cnt_r        <= cnt_nxt;
      idx_r        <= idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    hdr_r      <= hdr_nxt;
    empty_r    <= empty_nxt;
    len_r      <= len_nxt;
    seq_r      <= seq_nxt;
    addr_r     <= addr_nxt;
    ack_r      <= ack_nxt;
    data_r     <= data_nxt;
    out_byte_r <= out_byte_nxt;
    out_end_r  <= out_end_nxt;
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.out_byte  = out_byte_r;
  assign out_if.frame_end = out_end_r;

  // Header CRC sequence must have finished before the next item arrives
  a_step_done_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (step_r == STEP_IDLE))
    else $error("CRC sequencer still busy at input transfer");

  // Read position never passes the burst length
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= cnt_r)
    else $error("burst read position beyond burst length");

  // A payload item with no open frame leaves nothing to send
  a_stray_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_if.is_header && !frame_open_r) |=> (pending == '0))
    else $error("stray payload produced output");

  // CRC sequencer only runs for a header burst
  a_step_header_only: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r != STEP_IDLE) |-> hdr_r)
    else $error("CRC sequencer active outside header burst");

endmodule

`default_nettype wire
